### rtl/spi_nor_flash_command_sequencer_defines.svh
// assertion macros for the sequencer rtl
// depends on nothing; included by modules that carry assertions
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_DEFINES_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SNFCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SNFCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/snfcs_pkg.sv
// types, codes and constants of the spi nor flash command sequencer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package snfcs_pkg;

    localparam int          PAGE_BYTES_DEF  = 256;
    localparam logic [7:0]  DUMMY_VALUE_DEF = 8'hFF;
    localparam int          QUEUE_DEPTH_DEF = 4;

    typedef enum logic [3:0] {
        F_READ_ID     = 4'd0,
        F_READ_BEGIN  = 4'd1,
        F_READ_NEXT   = 4'd2,
        F_WRITE_BEGIN = 4'd3,
        F_WRITE_BYTE  = 4'd4,
        F_SECTOR_ERASE= 4'd5,
        F_BLOCK_ERASE = 4'd6,
        F_CHIP_ERASE  = 4'd7,
        F_STATUS      = 4'd8
    } t_func;

    typedef enum logic [2:0] {
        REG_WRITE_ENABLE = 3'd0,
        REG_READ_STATUS  = 3'd1,
        REG_PAGE_PROGRAM = 3'd2,
        REG_READ_DATA    = 3'd3,
        REG_READ_IDENT   = 3'd4,
        REG_SECTOR_ERASE = 3'd5,
        REG_BLOCK_ERASE  = 3'd6,
        REG_CHIP_ERASE   = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        J_ERR     = 4'd0,
        J_ACK     = 4'd1,
        J_RDID    = 4'd2,
        J_RDBEGIN = 4'd3,
        J_RDNEXT  = 4'd4,
        J_WBYTE   = 4'd5,
        J_ERASE   = 4'd6,
        J_CHIP    = 4'd7,
        J_STBUSY  = 4'd8,
        J_STDONE  = 4'd9
    } t_job_kind;

    typedef struct packed {
        logic [7:0] op_write_enable;
        logic [7:0] op_read_status;
        logic [7:0] op_page_program;
        logic [7:0] op_read_data;
        logic [7:0] op_read_ident;
        logic [7:0] op_sector_erase;
        logic [7:0] op_block_erase;
        logic [7:0] op_chip_erase;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  func;
        logic [23:0] address;
        logic [15:0] length;
        logic [7:0]  data_byte;
        logic [7:0]  status_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] mosi_byte;
        logic       send_byte;
        logic       select_before;
        logic       deselect_after;
        logic       capture_reply;
        logic       reply_is_status;
        logic       error_code;
        logic       last;
    } t_out_item;

    // flag_a: deselect on last byte (reads) or open a segment (write byte)
    // flag_b: write byte closes its segment and starts a poll
    typedef struct packed {
        t_job_kind   kind;
        logic [7:0]  op;
        logic [23:0] addr;
        logic [7:0]  data;
        logic        flag_a;
        logic        flag_b;
    } t_job;

endpackage

### rtl/spi_nor_flash_command_sequencer.sv
// Host-side SPI NOR flash sequencer. Each request or returned status byte is classified in
// the front part, which keeps the operation state, and queued as one job; the back part plays
// the job out as one to eight byte frames, one frame per clock while the consumer is ready,
// through a registered output. A request is taken while the job queue has room; a job
// gives 8 frames for a write byte that opens and closes a page segment, 7 for a sector or
// block erase, 6 for a write byte that only opens a segment, 4 for read id, read begin and
// chip erase, 3 for a write byte that only closes a segment and 1 for the rest, so the back
// part and the consumer set the sustained rate. Page size must be a power of two.
// depends on snfcs_pkg, snfcs_front, snfcs_queue and snfcs_back
`timescale 1ns / 1ps

module spi_nor_flash_command_sequencer
    import snfcs_pkg::*;
#(
    parameter int         PAGE_BYTES  = PAGE_BYTES_DEF,
    parameter logic [7:0] DUMMY_VALUE = DUMMY_VALUE_DEF,
    parameter int         QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_cfg r_cfg;
    t_job front_job, q_job;
    logic push, q_full, q_valid, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.op_write_enable <= 8'h06;
            r_cfg.op_read_status  <= 8'h05;
            r_cfg.op_page_program <= 8'h02;
            r_cfg.op_read_data    <= 8'h03;
            r_cfg.op_read_ident   <= 8'h9F;
            r_cfg.op_sector_erase <= 8'h20;
            r_cfg.op_block_erase  <= 8'hD8;
            r_cfg.op_chip_erase   <= 8'hC7;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_WRITE_ENABLE: r_cfg.op_write_enable <= i_cfg_data;
                REG_READ_STATUS:  r_cfg.op_read_status  <= i_cfg_data;
                REG_PAGE_PROGRAM: r_cfg.op_page_program <= i_cfg_data;
                REG_READ_DATA:    r_cfg.op_read_data    <= i_cfg_data;
                REG_READ_IDENT:   r_cfg.op_read_ident   <= i_cfg_data;
                REG_SECTOR_ERASE: r_cfg.op_sector_erase <= i_cfg_data;
                REG_BLOCK_ERASE:  r_cfg.op_block_erase  <= i_cfg_data;
                REG_CHIP_ERASE:   r_cfg.op_chip_erase   <= i_cfg_data;
                default:          r_cfg.op_chip_erase   <= r_cfg.op_chip_erase;
            endcase
        end
    end

    snfcs_front #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (front_job)
    );

    snfcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    snfcs_back #(
        .DUMMY_VALUE (DUMMY_VALUE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_job     (q_job),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

### rtl/snfcs_queue.sv
// small job fifo between the front and back parts of the sequencer
// depends on snfcs_pkg for the job type
`timescale 1ns / 1ps

module snfcs_queue
    import snfcs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/snfcs_front.sv
// front part: accepts requests, checks ordering, tracks the operation state
// and turns each request into one job; depends on snfcs_pkg
`timescale 1ns / 1ps

module snfcs_front
    import snfcs_pkg::*;
#(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    input  logic     i_q_full,
    output logic     o_push,
    output t_job     o_job
);

    // page size is a power of two: a page starts where the low bits are zero
    localparam int PAGE_W = $clog2(PAGE_BYTES);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_READING = 4'b0010,
        PH_WRITING = 4'b0100,
        PH_POLLING = 4'b1000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [23:0] r_cur_addr, n_cur_addr;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic        r_seg_open, n_seg_open;
    logic        r_resume, n_resume;

    logic [15:0] left_dec;
    logic [23:0] addr_inc;
    logic        close_seg;
    logic        accept;
    t_job        job;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept;
    assign o_job      = job;

    assign left_dec  = r_bytes_left - 16'd1;
    assign addr_inc  = r_cur_addr + 24'd1;
    assign close_seg = (left_dec == '0) || (addr_inc[PAGE_W-1:0] == '0);

    always_comb begin
        n_phase      = r_phase;
        n_cur_addr   = r_cur_addr;
        n_bytes_left = r_bytes_left;
        n_seg_open   = r_seg_open;
        n_resume     = r_resume;
        job.kind     = J_ERR;
        job.op       = '0;
        job.addr     = i_in_item.address;
        job.data     = i_in_item.data_byte;
        job.flag_a   = 1'b0;
        job.flag_b   = 1'b0;
        unique case (i_in_item.func)
            F_READ_ID: begin
                if (r_phase == PH_IDLE) begin
                    job.kind = J_RDID;
                    job.op   = i_cfg.op_read_ident;
                end
            end
            F_READ_BEGIN: begin
                if (r_phase == PH_IDLE) begin
                    job.kind   = J_RDBEGIN;
                    job.op     = i_cfg.op_read_data;
                    job.flag_a = (i_in_item.length == '0);
                    if (i_in_item.length != '0) begin
                        n_bytes_left = i_in_item.length;
                        n_phase      = PH_READING;
                    end
                end
            end
            F_READ_NEXT: begin
                if (r_phase == PH_READING && r_bytes_left != '0) begin
                    job.kind     = J_RDNEXT;
                    job.flag_a   = (left_dec == '0);
                    n_bytes_left = left_dec;
                    if (left_dec == '0) begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            F_WRITE_BEGIN: begin
                if (r_phase == PH_IDLE) begin
                    job.kind = J_ACK;
                    if (i_in_item.length != '0) begin
                        n_cur_addr   = i_in_item.address;
                        n_bytes_left = i_in_item.length;
                        n_seg_open   = 1'b0;
                        n_phase      = PH_WRITING;
                    end
                end
            end
            F_WRITE_BYTE: begin
                if (r_phase == PH_WRITING && r_bytes_left != '0) begin
                    job.kind     = J_WBYTE;
                    job.op       = i_cfg.op_page_program;
                    job.addr     = r_cur_addr;
                    job.flag_a   = !r_seg_open;
                    job.flag_b   = close_seg;
                    n_cur_addr   = addr_inc;
                    n_bytes_left = left_dec;
                    n_seg_open   = !close_seg;
                    if (close_seg) begin
                        n_phase  = PH_POLLING;
                        n_resume = (left_dec != '0);
                    end
                end
            end
            F_SECTOR_ERASE, F_BLOCK_ERASE: begin
                if (r_phase == PH_IDLE) begin
                    job.kind = J_ERASE;
                    job.op   = (i_in_item.func == F_SECTOR_ERASE) ?
                               i_cfg.op_sector_erase : i_cfg.op_block_erase;
                    n_phase  = PH_POLLING;
                    n_resume = 1'b0;
                end
            end
            F_CHIP_ERASE: begin
                if (r_phase == PH_IDLE) begin
                    job.kind = J_CHIP;
                    job.op   = i_cfg.op_chip_erase;
                    n_phase  = PH_POLLING;
                    n_resume = 1'b0;
                end
            end
            F_STATUS: begin
                if (r_phase == PH_POLLING) begin
                    if (i_in_item.status_value[0]) begin
                        job.kind = J_STBUSY;
                    end else begin
                        job.kind = J_STDONE;
                        n_phase  = r_resume ? PH_WRITING : PH_IDLE;
                        n_resume = 1'b0;
                    end
                end
            end
            default: begin
                job.kind = J_ERR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_cur_addr   <= '0;
            r_bytes_left <= '0;
            r_seg_open   <= 1'b0;
            r_resume     <= 1'b0;
        end else if (accept) begin
            r_phase      <= n_phase;
            r_cur_addr   <= n_cur_addr;
            r_bytes_left <= n_bytes_left;
            r_seg_open   <= n_seg_open;
            r_resume     <= n_resume;
        end
    end

endmodule

### rtl/snfcs_back.sv
// back part: expands each queued job into spi byte frames, one per unstalled cycle,
// into a registered output stage; depends on snfcs_pkg and the defines header
`timescale 1ns / 1ps
`include "spi_nor_flash_command_sequencer_defines.svh"

module snfcs_back
    import snfcs_pkg::*;
#(
    parameter logic [7:0] DUMMY_VALUE = DUMMY_VALUE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_valid,
    input  t_job      i_q_job,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    // a write byte without a segment to open skips write enable, opcode and address
    localparam logic [2:0] DATA_STEP = 3'd5;

    t_job       r_job;
    logic [2:0] r_step;
    logic       r_busy;
    t_out_item  r_out;
    logic       r_out_valid;

    t_out_item  frame;
    logic       load;

    function automatic t_out_item mk(input logic [7:0] b, input logic snd, input logic sel,
                                     input logic desel, input logic cap, input logic st,
                                     input logic err, input logic lst);
        t_out_item f;
        f.mosi_byte       = snd ? b : 8'd0;
        f.send_byte       = snd;
        f.select_before   = sel;
        f.deselect_after  = desel;
        f.capture_reply   = cap;
        f.reply_is_status = st;
        f.error_code      = err;
        f.last            = lst;
        return f;
    endfunction

    function automatic logic [7:0] addr_byte(input logic [23:0] a, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = a[23:16];
            2'd1:    b = a[15:8];
            default: b = a[7:0];
        endcase
        return b;
    endfunction

    always_comb begin
        frame = mk(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        unique case (r_job.kind)
            J_ERR: frame = mk(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
            J_ACK: frame = mk(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
            J_RDID: begin
                if (r_step == 3'd0) begin
                    frame = mk(r_job.op, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
                end else begin
                    frame = mk(DUMMY_VALUE, 1'b1, 1'b0, r_step == 3'd3, 1'b1, 1'b0, 1'b0,
                               r_step == 3'd3);
                end
            end
            J_RDBEGIN: begin
                if (r_step == 3'd0) begin
                    frame = mk(r_job.op, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
                end else begin
                    frame = mk(addr_byte(r_job.addr, 2'(r_step - 3'd1)), 1'b1, 1'b0,
                               r_job.flag_a && r_step == 3'd3, 1'b0, 1'b0, 1'b0,
                               r_step == 3'd3);
                end
            end
            J_RDNEXT: frame = mk(DUMMY_VALUE, 1'b1, 1'b0, r_job.flag_a, 1'b1, 1'b0, 1'b0, 1'b1);
            J_WBYTE: begin
                case (r_step)
                    3'd0: frame = mk(i_cfg.op_write_enable, 1'b1, 1'b1, 1'b1,
                                     1'b0, 1'b0, 1'b0, 1'b0);
                    3'd1: frame = mk(r_job.op, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
                    3'd2, 3'd3, 3'd4:
                          frame = mk(addr_byte(r_job.addr, 2'(r_step - 3'd2)), 1'b1, 1'b0,
                                     1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
                    3'd5: frame = mk(r_job.data, 1'b1, 1'b0, r_job.flag_b, 1'b0, 1'b0, 1'b0,
                                     !r_job.flag_b);
                    3'd6: frame = mk(i_cfg.op_read_status, 1'b1, 1'b1, 1'b0,
                                     1'b0, 1'b0, 1'b0, 1'b0);
                    default: frame = mk(DUMMY_VALUE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
                endcase
            end
            J_ERASE: begin
                case (r_step)
                    3'd0: frame = mk(i_cfg.op_write_enable, 1'b1, 1'b1, 1'b1,
                                     1'b0, 1'b0, 1'b0, 1'b0);
                    3'd1: frame = mk(r_job.op, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
                    3'd2, 3'd3, 3'd4:
                          frame = mk(addr_byte(r_job.addr, 2'(r_step - 3'd2)), 1'b1, 1'b0,
                                     r_step == 3'd4, 1'b0, 1'b0, 1'b0, 1'b0);
                    3'd5: frame = mk(i_cfg.op_read_status, 1'b1, 1'b1, 1'b0,
                                     1'b0, 1'b0, 1'b0, 1'b0);
                    default: frame = mk(DUMMY_VALUE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
                endcase
            end
            J_CHIP: begin
                case (r_step)
                    3'd0: frame = mk(i_cfg.op_write_enable, 1'b1, 1'b1, 1'b1,
                                     1'b0, 1'b0, 1'b0, 1'b0);
                    3'd1: frame = mk(r_job.op, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
                    3'd2: frame = mk(i_cfg.op_read_status, 1'b1, 1'b1, 1'b0,
                                     1'b0, 1'b0, 1'b0, 1'b0);
                    default: frame = mk(DUMMY_VALUE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
                endcase
            end
            J_STBUSY: frame = mk(DUMMY_VALUE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
            J_STDONE: frame = mk(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
            default:  frame = mk(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        endcase
    end

    assign load    = r_busy && (!r_out_valid || i_out_ready);
    assign o_q_pop = i_q_valid && (!r_busy || (load && frame.last));

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= frame;
        end
        if (o_q_pop) begin
            r_job <= i_q_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // a pop happens only when idle or on the last frame of the current job
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_step <= (i_q_job.kind == J_WBYTE && !i_q_job.flag_a) ? DATA_STEP : 3'd0;
            end else if (load) begin
                if (frame.last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step + 3'd1;
                end
            end
        end
    end

    `SNFCS_ASSERT_NEXT(a_job_held, i_clk, i_rst_n, load && !frame.last, r_busy,
                       "job dropped before its last frame")
    `SNFCS_ASSERT_NEXT(a_idle_when_drained, i_clk, i_rst_n,
                       load && frame.last && !i_q_valid, !r_busy,
                       "back still busy after its last frame")
    `SNFCS_ASSERT_NOW(a_error_single, i_clk, i_rst_n, r_out_valid && r_out.error_code,
                      r_out.last && !r_out.send_byte, "error result is not a lone frame")
    `SNFCS_ASSERT_NOW(a_no_byte_zero, i_clk, i_rst_n, r_out_valid && !r_out.send_byte,
                      r_out.mosi_byte == 8'd0, "byte shown on a frame without transfer")

endmodule

### bench/spi_nor_flash_command_sequencer_tb.sv
`timescale 1ns / 1ps
// self-checking bench for spi_nor_flash_command_sequencer: directed and random flash
// requests under bursty input and a stalling receiver, every frame checked in order
// depends on snfcs_pkg and the sequencer rtl

module spi_nor_flash_command_sequencer_tb;
    import snfcs_pkg::*;

    localparam int         PAGE_BYTES  = PAGE_BYTES_DEF;
    localparam logic [7:0] DUMMY_VALUE = DUMMY_VALUE_DEF;

    localparam t_cfg OPCODES_AT_RESET = '{
        op_write_enable: 8'h06, op_read_status: 8'h05, op_page_program: 8'h02,
        op_read_data: 8'h03, op_read_ident: 8'h9F, op_sector_erase: 8'h20,
        op_block_erase: 8'hD8, op_chip_erase: 8'hC7
    };

    typedef enum logic [1:0] {FL_IDLE, FL_READING, FL_WRITING, FL_POLLING} t_flash_phase;
    typedef enum int {RX_OPEN, RX_ALTERNATE, RX_RANDOM, RX_SPARSE, RX_LONG} t_stall;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic [2:0] i_cfg_idx  = '0;
    logic [7:0] i_cfg_data = '0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_in_item   i_in_item  = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_item  o_out_item;

    spi_nor_flash_command_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // mirror of the sequencer state
    t_cfg         opcodes;
    t_flash_phase flash_phase;
    logic [23:0]  cur_addr;
    logic [15:0]  left_bytes;
    logic         seg_open;
    logic         resume_write;

    t_out_item step_fr [0:7];
    int        step_n;
    t_out_item frames_due [$];
    t_in_item  req_backlog [$];
    t_out_item frame_want;

    int     mismatches     = 0;
    int     frames_checked = 0;
    int     reqs_taken     = 0;
    int     reqs_queued    = 0;
    int     gap_left       = 0;
    int     burst_left     = 0;
    bit     holding;
    int     stall_timer    = 0;
    t_stall stall_mode     = RX_OPEN;

    function automatic void add_frame(input logic [7:0] b, input logic send,
                                      input logic sel, input logic desel, input logic cap,
                                      input logic stat, input logic err);
        t_out_item f;
        f.mosi_byte       = send ? b : 8'h00;
        f.send_byte       = send;
        f.select_before   = sel;
        f.deselect_after  = desel;
        f.capture_reply   = cap;
        f.reply_is_status = stat;
        f.error_code      = err;
        f.last            = 1'b0;
        step_fr[step_n]   = f;
        step_n++;
    endfunction

    function automatic void add_addr(input logic [23:0] a, input logic desel_last);
        add_frame(a[23:16], 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_frame(a[15:8], 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_frame(a[7:0], 1'b1, 1'b0, desel_last, 1'b0, 1'b0, 1'b0);
    endfunction

    function automatic void start_poll(input logic resume);
        add_frame(opcodes.op_read_status, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        add_frame(DUMMY_VALUE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        flash_phase  = FL_POLLING;
        resume_write = resume;
    endfunction

    // works out the frames of one accepted request and updates the mirror state
    function automatic void predict_frames(input t_in_item it);
        logic closes;
        step_n = 0;
        if (it.func == F_READ_ID && flash_phase == FL_IDLE) begin
            add_frame(opcodes.op_read_ident, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
            add_frame(DUMMY_VALUE, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
            add_frame(DUMMY_VALUE, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
            add_frame(DUMMY_VALUE, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
        end else if (it.func == F_READ_BEGIN && flash_phase == FL_IDLE) begin
            add_frame(opcodes.op_read_data, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
            add_addr(it.address, it.length == 16'd0);
            if (it.length != 16'd0) begin
                left_bytes  = it.length;
                flash_phase = FL_READING;
            end
        end else if (it.func == F_READ_NEXT && flash_phase == FL_READING
                     && left_bytes != 16'd0) begin
            left_bytes = left_bytes - 16'd1;
            add_frame(DUMMY_VALUE, 1'b1, 1'b0, left_bytes == 16'd0, 1'b1, 1'b0, 1'b0);
            if (left_bytes == 16'd0)
                flash_phase = FL_IDLE;
        end else if (it.func == F_WRITE_BEGIN && flash_phase == FL_IDLE) begin
            add_frame(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            if (it.length != 16'd0) begin
                cur_addr    = it.address;
                left_bytes  = it.length;
                seg_open    = 1'b0;
                flash_phase = FL_WRITING;
            end
        end else if (it.func == F_WRITE_BYTE && flash_phase == FL_WRITING
                     && left_bytes != 16'd0) begin
            if (!seg_open) begin
                add_frame(opcodes.op_write_enable, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
                add_frame(opcodes.op_page_program, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
                add_addr(cur_addr, 1'b0);
                seg_open = 1'b1;
            end
            cur_addr   = cur_addr + 24'd1;
            left_bytes = left_bytes - 16'd1;
            closes     = (left_bytes == 16'd0) || ((cur_addr % PAGE_BYTES) == 0);
            add_frame(it.data_byte, 1'b1, 1'b0, closes, 1'b0, 1'b0, 1'b0);
            if (closes) begin
                seg_open = 1'b0;
                start_poll(left_bytes != 16'd0);
            end
        end else if ((it.func == F_SECTOR_ERASE || it.func == F_BLOCK_ERASE)
                     && flash_phase == FL_IDLE) begin
            add_frame(opcodes.op_write_enable, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
            add_frame(it.func == F_SECTOR_ERASE ? opcodes.op_sector_erase
                                                : opcodes.op_block_erase,
                      1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
            add_addr(it.address, 1'b1);
            start_poll(1'b0);
        end else if (it.func == F_CHIP_ERASE && flash_phase == FL_IDLE) begin
            add_frame(opcodes.op_write_enable, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
            add_frame(opcodes.op_chip_erase, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
            start_poll(1'b0);
        end else if (it.func == F_STATUS && flash_phase == FL_POLLING) begin
            if (it.status_value[0]) begin
                add_frame(DUMMY_VALUE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
            end else begin
                // release frame: chip select only
                add_frame(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
                flash_phase  = resume_write ? FL_WRITING : FL_IDLE;
                resume_write = 1'b0;
            end
        end else begin
            add_frame(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        end
        step_fr[step_n-1].last = 1'b1;
        for (int i = 0; i < step_n; i++)
            frames_due.push_back(step_fr[i]);
    endfunction

    function automatic t_in_item make_req(input logic [3:0] f, input logic [23:0] a,
                                          input logic [15:0] len, input logic [7:0] d,
                                          input logic [7:0] s);
        t_in_item r;
        r.func         = f;
        r.address      = a;
        r.length       = len;
        r.data_byte    = d;
        r.status_value = s;
        return r;
    endfunction

    function automatic t_in_item any_req(input logic [3:0] f);
        return make_req(f, 24'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    function automatic void queue_req(input t_in_item r);
        req_backlog.push_back(r);
        reqs_queued++;
    endfunction

    // now and then drop in a request that does not fit the current step
    function automatic void maybe_misorder(input t_func want);
        int f;
        if ($urandom_range(0, 11) == 0) begin
            do begin
                f = $urandom_range(0, 15);
            end while (f == int'(want));
            queue_req(any_req(4'(f)));
        end
    endfunction

    function automatic void queue_poll_replies();
        t_in_item r;
        int       busy;
        busy = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
        repeat (busy) begin
            maybe_misorder(F_STATUS);
            r = any_req(F_STATUS);
            r.status_value[0] = 1'b1;
            queue_req(r);
        end
        maybe_misorder(F_STATUS);
        r = any_req(F_STATUS);
        r.status_value[0] = 1'b0;
        queue_req(r);
    endfunction

    function automatic void queue_read(input logic [23:0] a, input int len);
        t_in_item r;
        r = any_req(F_READ_BEGIN);
        r.address = a;
        r.length  = 16'(len);
        queue_req(r);
        repeat (len) begin
            maybe_misorder(F_READ_NEXT);
            queue_req(any_req(F_READ_NEXT));
        end
    endfunction

    function automatic void queue_write(input logic [23:0] a, input int len);
        t_in_item    r;
        logic [23:0] wa;
        int          left;
        r = any_req(F_WRITE_BEGIN);
        r.address = a;
        r.length  = 16'(len);
        queue_req(r);
        wa   = a;
        left = len;
        while (left > 0) begin
            maybe_misorder(F_WRITE_BYTE);
            queue_req(any_req(F_WRITE_BYTE));
            wa = wa + 24'd1;
            left--;
            if (left == 0 || (wa % PAGE_BYTES) == 0)
                queue_poll_replies();
        end
    endfunction

    function automatic logic [23:0] pick_addr();
        case ($urandom_range(0, 3))
            0: return {16'($urandom), 8'hF0 | 8'($urandom_range(0, 15))};
            1: return 24'hFFFFF0 | 24'($urandom_range(0, 15));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic int pick_len(input int top);
        return ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, top);
    endfunction

    function automatic void queue_random(input int n);
        int stop;
        int pick;
        int f;
        stop = reqs_queued + n;
        while (reqs_queued < stop) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                queue_req(any_req(F_READ_ID));
            end else if (pick < 6) begin
                queue_read(pick_addr(), pick_len(8));
            end else if (pick < 12) begin
                queue_write(pick_addr(), pick_len(12));
            end else if (pick < 15) begin
                queue_req(any_req(pick < 14 ? F_SECTOR_ERASE : F_BLOCK_ERASE));
                queue_poll_replies();
            end else if (pick == 15) begin
                queue_req(any_req(F_CHIP_ERASE));
                queue_poll_replies();
            end else begin
                // stray request while idle
                do begin
                    f = $urandom_range(0, 15);
                end while (f inside {F_READ_ID, F_READ_BEGIN, F_WRITE_BEGIN,
                                     F_SECTOR_ERASE, F_BLOCK_ERASE, F_CHIP_ERASE});
                queue_req(any_req(4'(f)));
            end
        end
    endfunction

    function automatic void queue_directed();
        queue_req(make_req(F_READ_ID, 24'h000000, 16'h0000, 8'h00, 8'h00));
        // zero-length read: address only
        queue_req(make_req(F_READ_BEGIN, 24'hFFFFFF, 16'h0000, 8'hFF, 8'hFF));
        queue_req(make_req(F_READ_BEGIN, 24'h000000, 16'h0002, 8'h00, 8'h00));
        queue_req(make_req(F_READ_NEXT, 24'h000000, 16'hFFFF, 8'h00, 8'h00));
        queue_req(make_req(F_READ_NEXT, 24'hFFFFFF, 16'h0000, 8'hFF, 8'hFF));
        // zero-length write: ack only
        queue_req(make_req(F_WRITE_BEGIN, 24'h123456, 16'h0000, 8'h00, 8'h00));
        // write across the top of the address space, wraps to a fresh page
        queue_req(make_req(F_WRITE_BEGIN, 24'hFFFFFE, 16'h0003, 8'h00, 8'h00));
        queue_req(make_req(F_WRITE_BYTE, 24'h000000, 16'h0000, 8'h00, 8'h00));
        queue_req(make_req(F_WRITE_BYTE, 24'hFFFFFF, 16'hFFFF, 8'hFF, 8'hFF));
        queue_req(make_req(F_STATUS, 24'h000000, 16'h0000, 8'h00, 8'h01));
        queue_req(make_req(F_STATUS, 24'h000000, 16'h0000, 8'h00, 8'hFE));
        queue_req(make_req(F_WRITE_BYTE, 24'h000000, 16'h0000, 8'hA5, 8'h00));
        queue_req(make_req(F_STATUS, 24'h000000, 16'h0000, 8'h00, 8'h00));
        queue_req(make_req(F_SECTOR_ERASE, 24'hABCDEF, 16'h0000, 8'h00, 8'h00));
        queue_req(make_req(F_STATUS, 24'h000000, 16'h0000, 8'h00, 8'hFF));
        queue_req(make_req(F_STATUS, 24'h000000, 16'h0000, 8'h00, 8'h00));
        queue_req(make_req(F_BLOCK_ERASE, 24'h000000, 16'h0000, 8'h00, 8'h00));
        queue_req(make_req(F_STATUS, 24'h000000, 16'h0000, 8'h00, 8'h00));
        queue_req(make_req(F_CHIP_ERASE, 24'h000000, 16'h0000, 8'h00, 8'h00));
        queue_req(make_req(F_STATUS, 24'h000000, 16'h0000, 8'h00, 8'h00));
        // out-of-order and unknown requests while idle
        queue_req(make_req(4'hF, 24'hFFFFFF, 16'hFFFF, 8'hFF, 8'hFF));
        queue_req(make_req(F_READ_NEXT, 24'h000000, 16'h0000, 8'h00, 8'h00));
        queue_req(make_req(F_STATUS, 24'h000000, 16'h0000, 8'h00, 8'h00));
        queue_req(make_req(F_WRITE_BYTE, 24'h000000, 16'h0000, 8'h00, 8'h00));
    endfunction

    task automatic write_opcode(input t_reg_idx idx, input logic [7:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
    endtask

    task automatic load_opcodes(input t_cfg c);
        write_opcode(REG_WRITE_ENABLE, c.op_write_enable);
        write_opcode(REG_READ_STATUS, c.op_read_status);
        write_opcode(REG_PAGE_PROGRAM, c.op_page_program);
        write_opcode(REG_READ_DATA, c.op_read_data);
        write_opcode(REG_READ_IDENT, c.op_read_ident);
        write_opcode(REG_SECTOR_ERASE, c.op_sector_erase);
        write_opcode(REG_BLOCK_ERASE, c.op_block_erase);
        write_opcode(REG_CHIP_ERASE, c.op_chip_erase);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        opcodes = c;
    endtask

    task automatic drain();
        while (req_backlog.size() != 0 || i_in_valid || frames_due.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    // request driver: bursts with random gaps, prediction on each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            holding = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                predict_frames(i_in_item);
                reqs_taken++;
                holding = 1'b0;
            end
            if (!holding) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (req_backlog.size() != 0) begin
                    i_in_item  <= req_backlog.pop_front();
                    i_in_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                                 : $urandom_range(1, 8);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // frame receiver: readiness follows a stall pattern picked at random from five modes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            stall_timer++;
            if (stall_timer % 48 == 0)
                stall_mode = t_stall'($urandom_range(0, 4));
            case (stall_mode)
                RX_OPEN:      i_out_ready <= 1'b1;
                RX_ALTERNATE: i_out_ready <= stall_timer[0];
                RX_RANDOM:    i_out_ready <= ($urandom_range(0, 9) < 7);
                RX_SPARSE:    i_out_ready <= (stall_timer % 4 == 0);
                default:      i_out_ready <= (stall_timer % 16 > 11);
            endcase
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frames_due.size() == 0) begin
                $error("frame with nothing outstanding: %p", o_out_item);
                mismatches++;
            end else begin
                frame_want = frames_due.pop_front();
                check_field("mosi_byte", frame_want.mosi_byte, o_out_item.mosi_byte);
                check_field("send_byte", frame_want.send_byte, o_out_item.send_byte);
                check_field("select_before", frame_want.select_before,
                            o_out_item.select_before);
                check_field("deselect_after", frame_want.deselect_after,
                            o_out_item.deselect_after);
                check_field("capture_reply", frame_want.capture_reply,
                            o_out_item.capture_reply);
                check_field("reply_is_status", frame_want.reply_is_status,
                            o_out_item.reply_is_status);
                check_field("error_code", frame_want.error_code, o_out_item.error_code);
                check_field("last", frame_want.last, o_out_item.last);
                frames_checked++;
            end
        end
    end

    initial begin
        opcodes      = OPCODES_AT_RESET;
        flash_phase  = FL_IDLE;
        cur_addr     = '0;
        left_bytes   = '0;
        seg_open     = 1'b0;
        resume_write = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_directed();
        drain();

        load_opcodes('1);
        queue_random(48);
        drain();

        load_opcodes('0);
        queue_random(48);
        drain();

        load_opcodes(t_cfg'({$urandom, $urandom}));
        queue_random(48);
        drain();

        load_opcodes(OPCODES_AT_RESET);
        queue_random(48);
        drain();

        $display("%0d requests taken, %0d frames checked over five opcode settings",
                 reqs_taken, frames_checked);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/snfcs_pkg.sv
rtl/snfcs_queue.sv
rtl/snfcs_front.sv
rtl/snfcs_back.sv
rtl/spi_nor_flash_command_sequencer.sv
bench/spi_nor_flash_command_sequencer_tb.sv
